### src/nvpld_pkg.sv
// Shared types and constants for the name-value pair length decoder.
package nvpld_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 31;
    localparam int ROLE_W = 2;
    localparam int CNT_W  = 2;

    localparam logic [BYTE_W-1:0] LONG_LENGTH_FLAG = 8'h80;
    localparam logic [CNT_W-1:0]  LONG_EXTRA_BYTES = 2'd3;

    typedef enum logic [2:0] {
        PH_NLEN      = 3'd0,
        PH_NLEN_MORE = 3'd1,
        PH_VLEN      = 3'd2,
        PH_VLEN_MORE = 3'd3,
        PH_NAME      = 3'd4,
        PH_VALUE     = 3'd5
    } phase_t;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_NAME_LEN  = 2'd0,
        ROLE_VALUE_LEN = 2'd1,
        ROLE_NAME      = 2'd2,
        ROLE_VALUE     = 2'd3
    } role_t;

    typedef struct packed {
        phase_t           phase;
        logic [CNT_W-1:0] length_byte_count;
        logic [LEN_W-1:0] name_length_acc;
        logic [LEN_W-1:0] value_length_acc;
        logic [LEN_W-1:0] bytes_left;
    } dec_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        role_t             byte_role;
        logic              pair_end;
        logic [LEN_W-1:0]  pair_name_length;
        logic [LEN_W-1:0]  pair_value_length;
        logic              at_name_start;
    } dec_result_t;

endpackage

### src/nvpld_step.sv
// Per-byte decode step: next parser state and tagged result for one byte.
module nvpld_step (
    input  nvpld_pkg::dec_state_t       state,
    input  logic [nvpld_pkg::BYTE_W-1:0] stream_byte,
    output nvpld_pkg::dec_state_t       state_next,
    output nvpld_pkg::dec_result_t      result
);
    import nvpld_pkg::*;

    logic [LEN_W-1:0] low7;
    logic [LEN_W-1:0] byte_ext;
    logic [LEN_W-1:0] left_dec;
    logic [CNT_W-1:0] cnt_dec;
    logic             is_long;
    logic             cnt_last;
    logic             left_last;

    assign low7      = {{(LEN_W-7){1'b0}}, stream_byte[6:0]};
    assign byte_ext  = {{(LEN_W-BYTE_W){1'b0}}, stream_byte};
    assign left_dec  = state.bytes_left - LEN_W'(1);
    assign cnt_dec   = state.length_byte_count - CNT_W'(1);
    assign is_long   = (stream_byte & LONG_LENGTH_FLAG) != '0;
    assign cnt_last  = state.length_byte_count <= CNT_W'(1);
    assign left_last = state.bytes_left <= LEN_W'(1);

    always_comb
    begin
        logic end_pair;
        logic name_start;
        role_t role;

        state_next = state;
        end_pair   = 1'b0;
        name_start = 1'b0;
        role       = ROLE_NAME_LEN;

        case (state.phase)
            PH_NLEN_MORE:
            begin
                role = ROLE_NAME_LEN;
                state_next.name_length_acc = {state.name_length_acc[LEN_W-9:0], stream_byte};
                if (cnt_last)
                begin
                    state_next.length_byte_count = '0;
                    state_next.phase = PH_VLEN;
                end
                else
                begin
                    state_next.length_byte_count = cnt_dec;
                end
            end
            PH_VLEN, PH_VLEN_MORE:
            begin
                role = ROLE_VALUE_LEN;
                if (state.phase == PH_VLEN && is_long)
                begin
                    state_next.value_length_acc  = low7;
                    state_next.length_byte_count = LONG_EXTRA_BYTES;
                    state_next.phase             = PH_VLEN_MORE;
                end
                else if (state.phase == PH_VLEN_MORE && !cnt_last)
                begin
                    state_next.value_length_acc =
                        {state.value_length_acc[LEN_W-9:0], stream_byte};
                    state_next.length_byte_count = cnt_dec;
                end
                else
                begin
                    // final value length byte: both lengths known
                    if (state.phase == PH_VLEN)
                    begin
                        state_next.value_length_acc = byte_ext;
                    end
                    else
                    begin
                        state_next.value_length_acc =
                            {state.value_length_acc[LEN_W-9:0], stream_byte};
                        state_next.length_byte_count = '0;
                    end
                    if (state.name_length_acc != '0)
                    begin
                        state_next.phase      = PH_NAME;
                        state_next.bytes_left = state.name_length_acc;
                    end
                    else if (state_next.value_length_acc != '0)
                    begin
                        state_next.phase      = PH_VALUE;
                        state_next.bytes_left = state_next.value_length_acc;
                    end
                    else
                    begin
                        state_next.phase = PH_NLEN;
                        end_pair         = 1'b1;
                    end
                end
            end
            PH_NAME:
            begin
                role       = ROLE_NAME;
                name_start = (state.bytes_left == state.name_length_acc);
                if (left_last)
                begin
                    if (state.value_length_acc != '0)
                    begin
                        state_next.phase      = PH_VALUE;
                        state_next.bytes_left = state.value_length_acc;
                    end
                    else
                    begin
                        state_next.phase      = PH_NLEN;
                        state_next.bytes_left = '0;
                        end_pair              = 1'b1;
                    end
                end
                else
                begin
                    state_next.bytes_left = left_dec;
                end
            end
            PH_VALUE:
            begin
                role = ROLE_VALUE;
                if (left_last)
                begin
                    state_next.bytes_left = '0;
                    state_next.phase      = PH_NLEN;
                    end_pair              = 1'b1;
                end
                else
                begin
                    state_next.bytes_left = left_dec;
                end
            end
            default:
            begin
                // start of a pair: first name length byte
                role = ROLE_NAME_LEN;
                if (is_long)
                begin
                    state_next.name_length_acc   = low7;
                    state_next.length_byte_count = LONG_EXTRA_BYTES;
                    state_next.phase             = PH_NLEN_MORE;
                end
                else
                begin
                    state_next.name_length_acc   = byte_ext;
                    state_next.length_byte_count = '0;
                    state_next.phase             = PH_VLEN;
                end
            end
        endcase

        result.echo_byte         = stream_byte;
        result.byte_role         = role;
        result.pair_end          = end_pair;
        result.pair_name_length  = end_pair ? state_next.name_length_acc : '0;
        result.pair_value_length = end_pair ? state_next.value_length_acc : '0;
        result.at_name_start     = name_start;
    end

endmodule

### src/name_value_pair_length_decoder.sv
// Top level of the name-value pair length decoder.
//
// Usage:
//   Input channel (in_valid / in_ready / stream_byte) carries the pair
//   stream one byte per transaction. Output channel (out_valid / out_ready)
//   carries one tagged result per input byte: the byte itself, its role,
//   the pair-end mark with both decoded lengths, and the first-name-byte
//   mark.
//   Output: a result is registered and appears at the output in the cycle
//   after its byte is accepted. Throughput: one byte per cycle while the
//   output is not stalled; the parser state and the result register are
//   both updated in the accepting cycle, so the only loop is the state update.
//   Stall: while out_valid is high and out_ready low, the result register
//   holds and in_ready drops; the parser state does not advance. A new
//   byte is taken in the same cycle the waiting result leaves.
//   Reset: rst_n clears the parser to the start of a pair (expecting a
//   name length byte) and empties the result register.
module name_value_pair_length_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [nvpld_pkg::BYTE_W-1:0]      stream_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [nvpld_pkg::BYTE_W-1:0]      echo_byte,
    output logic [nvpld_pkg::ROLE_W-1:0]      byte_role,
    output logic                              pair_end,
    output logic [nvpld_pkg::LEN_W-1:0]       pair_name_length,
    output logic [nvpld_pkg::LEN_W-1:0]       pair_value_length,
    output logic                              at_name_start
);
    import nvpld_pkg::*;

    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t result_reg;
    dec_result_t result_next;
    logic        out_valid_reg;
    logic        in_fire;

    // accept whenever the result register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    nvpld_step u_step (
        .state       (state_reg),
        .stream_byte (stream_byte),
        .state_next  (state_next),
        .result      (result_next)
    );

    // parser state: advance only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase             <= PH_NLEN;
            state_reg.length_byte_count <= '0;
            state_reg.name_length_acc   <= '0;
            state_reg.value_length_acc  <= '0;
            state_reg.bytes_left        <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result valid flag: set on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign echo_byte         = result_reg.echo_byte;
    assign byte_role         = result_reg.byte_role;
    assign pair_end          = result_reg.pair_end;
    assign pair_name_length  = result_reg.pair_name_length;
    assign pair_value_length = result_reg.pair_value_length;
    assign at_name_start     = result_reg.at_name_start;

endmodule

### src/nvpld_checker.sv
// Port-level assertions for the name-value pair length decoder, with bind.
module nvpld_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [nvpld_pkg::BYTE_W-1:0] echo_byte,
    input logic [nvpld_pkg::ROLE_W-1:0] byte_role,
    input logic                         pair_end,
    input logic [nvpld_pkg::LEN_W-1:0]  pair_name_length,
    input logic [nvpld_pkg::LEN_W-1:0]  pair_value_length,
    input logic                         at_name_start
);
    import nvpld_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(echo_byte) && $stable(byte_role))
        else $error("stalled result changed");

    // an empty result slot never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // lengths are shown only on the pair-ending byte
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pair_end |-> pair_name_length == '0 && pair_value_length == '0)
        else $error("lengths shown off a pair end");

    // first-name mark only on name bytes
    a_start_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_name_start |-> byte_role == ROLE_NAME)
        else $error("name start on a non-name byte");

    // a pair ending on a name byte has a non-empty name and an empty value
    a_name_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_end && byte_role == ROLE_NAME
            |-> pair_name_length != '0 && pair_value_length == '0)
        else $error("bad lengths on name-ending pair");

endmodule

bind name_value_pair_length_decoder nvpld_checker u_nvpld_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .echo_byte         (echo_byte),
    .byte_role         (byte_role),
    .pair_end          (pair_end),
    .pair_name_length  (pair_name_length),
    .pair_value_length (pair_value_length),
    .at_name_start     (at_name_start)
);
